### design/bvfs_pkg.sv
// Shared constants, request codes and the stored record layout of the
// bilinear vector field sampler. No dependencies.
package bvfs_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int FRAC_BITS  = 8;

	localparam int X_W     = $clog2(MAX_WIDTH);
	localparam int Y_W     = $clog2(MAX_HEIGHT);
	localparam int ADDR_W  = X_W + Y_W;
	localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;

	localparam int VAL_W     = 16;
	localparam int COORD_W   = 20;
	localparam int DIM_W     = 9;
	localparam int CFG_IDX_W = 1;
	localparam int XI_W      = COORD_W - 1 - FRAC_BITS;
	localparam int PX_W      = X_W + FRAC_BITS;
	localparam int PY_W      = Y_W + FRAC_BITS;

	localparam int FW      = FRAC_BITS + 1;
	localparam int ONE_F   = 1 << FRAC_BITS;
	localparam int WGT_W   = 2 * FRAC_BITS + 1;
	localparam int PROD_W  = 2 * VAL_W + 1;
	localparam int ACC_W   = PROD_W + WGT_W + 3;

	localparam int ONE_DIR = 16384;
	localparam int DQ_W    = 15;
	localparam int SQ_W    = 64;
	localparam int ROOT_W  = 32;
	localparam int MAG_W   = 32;
	localparam int BV_W    = MAG_W + 1;

	typedef enum logic [1:0] {
		REQ_WRITE  = 2'd0,
		REQ_SAMPLE = 2'd1,
		REQ_CLEAR  = 2'd2
	} req_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [VAL_W-1:0] distance;
		logic [VAL_W-1:0] dir_x;
		logic [VAL_W-1:0] dir_y;
		logic [VAL_W-1:0] radius;
		logic [VAL_W-1:0] tim;
		logic [VAL_W-1:0] vel_x;
		logic [VAL_W-1:0] vel_y;
	} rec_t;

endpackage

### design/bvfs_intf.sv
// Request and result channel interfaces (valid/ready plus payload).
// Depends on bvfs_pkg.
interface bvfs_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           req_type;
	logic signed [bvfs_pkg::COORD_W-1:0]  coord_x;
	logic signed [bvfs_pkg::COORD_W-1:0]  coord_y;
	logic [bvfs_pkg::VAL_W-1:0]           in_dist;
	logic signed [bvfs_pkg::VAL_W-1:0]    in_dir_x;
	logic signed [bvfs_pkg::VAL_W-1:0]    in_dir_y;
	logic [bvfs_pkg::VAL_W-1:0]           in_radius;
	logic [bvfs_pkg::VAL_W-1:0]           in_time;
	logic signed [bvfs_pkg::VAL_W-1:0]    in_vel_x;
	logic signed [bvfs_pkg::VAL_W-1:0]    in_vel_y;

	modport source(output valid, req_type, coord_x, coord_y, in_dist, in_dir_x, in_dir_y,
		in_radius, in_time, in_vel_x, in_vel_y, input ready);
	modport sink(input valid, req_type, coord_x, coord_y, in_dist, in_dir_x, in_dir_y,
		in_radius, in_time, in_vel_x, in_vel_y, output ready);
endinterface

interface bvfs_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [bvfs_pkg::VAL_W-1:0]         out_dist;
	logic signed [bvfs_pkg::VAL_W-1:0]  out_dir_x;
	logic signed [bvfs_pkg::VAL_W-1:0]  out_dir_y;
	logic [bvfs_pkg::VAL_W-1:0]         out_radius;
	logic [bvfs_pkg::VAL_W-1:0]         out_time;
	logic signed [bvfs_pkg::VAL_W-1:0]  out_vel_x;
	logic signed [bvfs_pkg::VAL_W-1:0]  out_vel_y;

	modport source(output valid, out_dist, out_dir_x, out_dir_y, out_radius, out_time,
		out_vel_x, out_vel_y, input ready);
	modport sink(input valid, out_dist, out_dir_x, out_dir_y, out_radius, out_time,
		out_vel_x, out_vel_y, output ready);
endinterface

### design/bvfs_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module bvfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

### design/bvfs_sqrt.sv
// Iterative floor square root, one result bit per cycle.
// Depends on bvfs_pkg.
module bvfs_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bvfs_pkg::SQ_W-1:0]   op,
	output logic                        done,
	output logic [bvfs_pkg::ROOT_W-1:0] root
);

	logic [bvfs_pkg::SQ_W-1:0] rem_q;
	logic [bvfs_pkg::SQ_W-1:0] res_q;
	logic [bvfs_pkg::SQ_W-1:0] one_q;
	logic [bvfs_pkg::SQ_W:0]   trial;
	logic                      busy_q;
	logic                      done_q;

	assign trial = {1'b0, res_q} + {1'b0, one_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && one_q == bvfs_pkg::SQ_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= op;
			res_q <= '0;
			one_q <= bvfs_pkg::SQ_W'(1) << (bvfs_pkg::SQ_W - 2);
		end else if (busy_q) begin
			if ({1'b0, rem_q} >= trial) begin
				rem_q <= rem_q - trial[bvfs_pkg::SQ_W-1:0];
				res_q <= (res_q >> 1) + one_q;
			end else begin
				res_q <= res_q >> 1;
			end
			one_q <= one_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[bvfs_pkg::ROOT_W-1:0];

endmodule

### design/bvfs_div.sv
// Normalizing divider: q = round(m * 16384 / r) for both vector components,
// restoring, one quotient bit per cycle. Depends on bvfs_pkg.
module bvfs_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bvfs_pkg::MAG_W-1:0]  mag_x,
	input  logic [bvfs_pkg::MAG_W-1:0]  mag_y,
	input  logic [bvfs_pkg::ROOT_W-1:0] root,
	output logic                        done,
	output logic [bvfs_pkg::DQ_W-1:0]   q_x,
	output logic [bvfs_pkg::DQ_W-1:0]   q_y
);

	localparam int NUM_W = bvfs_pkg::MAG_W + bvfs_pkg::DQ_W + 2;
	localparam int CNT_W = $clog2(bvfs_pkg::DQ_W);

	logic [NUM_W-1:0]            rem_x_q;
	logic [NUM_W-1:0]            rem_y_q;
	logic [NUM_W-1:0]            den_q;
	logic [bvfs_pkg::DQ_W-1:0]   qx_q;
	logic [bvfs_pkg::DQ_W-1:0]   qy_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic                        ge_x;
	logic                        ge_y;

	assign ge_x = rem_x_q >= den_q;
	assign ge_y = rem_y_q >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(bvfs_pkg::DQ_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// numerator m*2^15 + r over divisor 2r, top quotient bit first
	always_ff @(posedge clk) begin
		if (start) begin
			rem_x_q <= (NUM_W'(mag_x) << bvfs_pkg::DQ_W) + NUM_W'(root);
			rem_y_q <= (NUM_W'(mag_y) << bvfs_pkg::DQ_W) + NUM_W'(root);
			den_q   <= NUM_W'(root) << bvfs_pkg::DQ_W;
			qx_q    <= '0;
			qy_q    <= '0;
		end else if (busy_q) begin
			if (ge_x) begin
				rem_x_q <= rem_x_q - den_q;
			end
			if (ge_y) begin
				rem_y_q <= rem_y_q - den_q;
			end
			qx_q  <= {qx_q[bvfs_pkg::DQ_W-2:0], ge_x};
			qy_q  <= {qy_q[bvfs_pkg::DQ_W-2:0], ge_y};
			den_q <= den_q >> 1;
		end
	end

	assign done = done_q;
	assign q_x  = (qx_q > bvfs_pkg::DQ_W'(bvfs_pkg::ONE_DIR)) ?
		bvfs_pkg::DQ_W'(bvfs_pkg::ONE_DIR) : qx_q;
	assign q_y  = (qy_q > bvfs_pkg::DQ_W'(bvfs_pkg::ONE_DIR)) ?
		bvfs_pkg::DQ_W'(bvfs_pkg::ONE_DIR) : qy_q;

endmodule

### design/bilinear_vector_field_sampler.sv
// Top level: record store, request sequencer, corner blend, length and normalize.
// Depends on bvfs_pkg, bvfs_intf, bvfs_ram, bvfs_sqrt, bvfs_div.
//
//  channel  dir  handshake        payload
//  req      in   valid/ready      req_type, coord_x/y, in_* record fields
//  rsp      out  valid/ready      out_dist, out_dir_x/y, out_radius/time/vel_x/vel_y
//  cfg      in   cfg_wen          cfg_index, cfg_data (9 bits)
//
// Write and unknown requests are done once accepted; clear writes every entry, one entry a cycle.
// A sample reads the four corners through the single RAM port, then runs the bit-serial
// square root (32 steps) and then the normalizing divide.
// After reset a clearing pass over every entry runs; req.ready stays low during it.
// The result sits in an output register, so the next request is taken while it waits;
// a later sample stalls only in its last step until that register is free.
module bilinear_vector_field_sampler (
	input  logic                             clk,
	input  logic                             arst_n,
	bvfs_req_if.sink                         req,
	bvfs_rsp_if.source                       rsp,
	input  logic                             cfg_wen,
	input  logic [bvfs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bvfs_pkg::DIM_W-1:0]       cfg_data
);

	typedef enum logic [7:0] {
		ST_CLEAR  = 8'b00000001,
		ST_IDLE   = 8'b00000010,
		ST_READ   = 8'b00000100,
		ST_ROUND  = 8'b00001000,
		ST_SQUARE = 8'b00010000,
		ST_ROOT   = 8'b00100000,
		ST_DIV    = 8'b01000000,
		ST_DONE   = 8'b10000000
	} state_t;

	localparam int AW  = bvfs_pkg::ACC_W;
	localparam int VW  = bvfs_pkg::VAL_W;
	localparam int DW  = bvfs_pkg::DIM_W;
	localparam int RSH = 2 * bvfs_pkg::FRAC_BITS;

	state_t                          state_q;
	logic [DW-1:0]                   width_q;
	logic [DW-1:0]                   height_q;
	logic [DW-1:0]                   w_eff;
	logic [DW-1:0]                   h_eff;
	logic [bvfs_pkg::X_W-1:0]        wm2;
	logic [bvfs_pkg::Y_W-1:0]        hm2;

	logic                            acc_in;
	logic                            wr_ok;
	logic [bvfs_pkg::XI_W-1:0]       wr_x;
	logic [bvfs_pkg::XI_W-1:0]       wr_y;
	logic [bvfs_pkg::PX_W-1:0]       hi_x;
	logic [bvfs_pkg::PY_W-1:0]       hi_y;
	logic [bvfs_pkg::PX_W-1:0]       px;
	logic [bvfs_pkg::PY_W-1:0]       py;
	logic [bvfs_pkg::FW-1:0]         fx;
	logic [bvfs_pkg::FW-1:0]         fy;
	logic [bvfs_pkg::FW-1:0]         gx;
	logic [bvfs_pkg::FW-1:0]         gy;

	logic [bvfs_pkg::X_W-1:0]        i0_q;
	logic [bvfs_pkg::Y_W-1:0]        j0_q;
	logic [bvfs_pkg::WGT_W-1:0]      wgt_q [4];
	logic [VW-1:0]                   fill_q;
	logic [bvfs_pkg::ADDR_W-1:0]     clr_addr_q;
	logic [2:0]                      rd_cnt_q;
	logic [1:0]                      corner;
	logic [bvfs_pkg::X_W-1:0]        rd_x;
	logic [bvfs_pkg::Y_W-1:0]        rd_y;

	logic                            ram_we;
	logic [bvfs_pkg::ADDR_W-1:0]     ram_addr;
	bvfs_pkg::rec_t                  ram_wdata;
	bvfs_pkg::rec_t                  ram_rdata;

	logic                            v1_s1;
	logic signed [bvfs_pkg::PROD_W-1:0] pvx_s1;
	logic signed [bvfs_pkg::PROD_W-1:0] pvy_s1;
	logic [VW-1:0]                   rad_s1;
	logic [VW-1:0]                   tim_s1;
	logic signed [VW-1:0]            ux_s1;
	logic signed [VW-1:0]            uy_s1;
	logic [bvfs_pkg::WGT_W-1:0]      wgt_s1;
	logic signed [bvfs_pkg::WGT_W:0] wgt_sg;

	logic signed [AW-1:0]            acc_vx_q;
	logic signed [AW-1:0]            acc_vy_q;
	logic signed [AW-1:0]            acc_rad_q;
	logic signed [AW-1:0]            acc_tim_q;
	logic signed [AW-1:0]            acc_ux_q;
	logic signed [AW-1:0]            acc_uy_q;

	logic signed [bvfs_pkg::BV_W-1:0] bx_q;
	logic signed [bvfs_pkg::BV_W-1:0] by_q;
	logic [VW-1:0]                   rad_q;
	logic [VW-1:0]                   tim_q;
	logic [VW-1:0]                   ux_q;
	logic [VW-1:0]                   uy_q;
	logic signed [2*bvfs_pkg::BV_W-1:0] sqx;
	logic signed [2*bvfs_pkg::BV_W-1:0] sqy;
	logic [bvfs_pkg::SQ_W-1:0]       sq_sum;
	logic [bvfs_pkg::MAG_W-1:0]      mag_x;
	logic [bvfs_pkg::MAG_W-1:0]      mag_y;

	logic                            sqrt_start;
	logic                            sqrt_done;
	logic [bvfs_pkg::ROOT_W-1:0]     root;
	logic [bvfs_pkg::ROOT_W-1:0]     len_q;
	logic                            div_start;
	logic                            div_done;
	logic [bvfs_pkg::DQ_W-1:0]       q_x;
	logic [bvfs_pkg::DQ_W-1:0]       q_y;
	logic [bvfs_pkg::DQ_W-1:0]       qx_q;
	logic [bvfs_pkg::DQ_W-1:0]       qy_q;

	logic                            out_valid_q;
	logic                            out_load;
	logic [bvfs_pkg::ROOT_W-1:0]     dist_rnd;
	logic [VW-1:0]                   o_dist_q;
	logic [VW-1:0]                   o_dir_x_q;
	logic [VW-1:0]                   o_dir_y_q;
	logic [VW-1:0]                   o_rad_q;
	logic [VW-1:0]                   o_tim_q;
	logic [VW-1:0]                   o_vx_q;
	logic [VW-1:0]                   o_vy_q;

	// divide by 2^(2F), half away from zero
	function automatic logic signed [AW-1:0] rnd(input logic signed [AW-1:0] v);
		logic [AW-1:0] m;
		m = v[AW-1] ? AW'(-v) : AW'(v);
		m = (m + (AW'(1) << (RSH - 1))) >> RSH;
		return v[AW-1] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic [VW-1:0] sat_u(input logic signed [AW-1:0] v);
		if (v < 0) begin
			return '0;
		end else if (v > AW'(65535)) begin
			return '1;
		end
		return v[VW-1:0];
	endfunction

	function automatic logic [VW-1:0] sat_s(input logic signed [AW-1:0] v);
		if (v > AW'(32767)) begin
			return 16'h7FFF;
		end else if (v < -AW'(32768)) begin
			return 16'h8000;
		end
		return v[VW-1:0];
	endfunction

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DW'(256);
			height_q <= DW'(256);
		end else if (cfg_wen) begin
			unique case (bvfs_pkg::cfg_reg_t'(cfg_index))
				bvfs_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				bvfs_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		w_eff = (width_q < DW'(2)) ? DW'(2) :
			((width_q > DW'(bvfs_pkg::MAX_WIDTH)) ? DW'(bvfs_pkg::MAX_WIDTH) : width_q);
		h_eff = (height_q < DW'(2)) ? DW'(2) :
			((height_q > DW'(bvfs_pkg::MAX_HEIGHT)) ? DW'(bvfs_pkg::MAX_HEIGHT) : height_q);
		wm2 = bvfs_pkg::X_W'(w_eff - DW'(2));
		hm2 = bvfs_pkg::Y_W'(h_eff - DW'(2));
	end

	assign acc_in    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);

	// write target pixel
	assign wr_x  = req.coord_x[bvfs_pkg::COORD_W-2:bvfs_pkg::FRAC_BITS];
	assign wr_y  = req.coord_y[bvfs_pkg::COORD_W-2:bvfs_pkg::FRAC_BITS];
	assign wr_ok = !req.coord_x[bvfs_pkg::COORD_W-1] && !req.coord_y[bvfs_pkg::COORD_W-1]
		&& (wr_x < bvfs_pkg::XI_W'(w_eff)) && (wr_y < bvfs_pkg::XI_W'(h_eff));

	// sample coordinate clamp and weights
	always_comb begin
		hi_x = {wm2, bvfs_pkg::FRAC_BITS'(0)};
		hi_y = {hm2, bvfs_pkg::FRAC_BITS'(0)};
		if (req.coord_x[bvfs_pkg::COORD_W-1]) begin
			px = '0;
		end else if (req.coord_x > $signed(bvfs_pkg::COORD_W'(hi_x))) begin
			px = hi_x;
		end else begin
			px = req.coord_x[bvfs_pkg::PX_W-1:0];
		end
		if (req.coord_y[bvfs_pkg::COORD_W-1]) begin
			py = '0;
		end else if (req.coord_y > $signed(bvfs_pkg::COORD_W'(hi_y))) begin
			py = hi_y;
		end else begin
			py = req.coord_y[bvfs_pkg::PY_W-1:0];
		end
		fx = bvfs_pkg::FW'(px[bvfs_pkg::FRAC_BITS-1:0]);
		fy = bvfs_pkg::FW'(py[bvfs_pkg::FRAC_BITS-1:0]);
		gx = bvfs_pkg::FW'(bvfs_pkg::ONE_F) - fx;
		gy = bvfs_pkg::FW'(bvfs_pkg::ONE_F) - fy;
	end

	// corner order: (i0,j0) (i1,j0) (i0,j1) (i1,j1)
	assign corner = rd_cnt_q[1:0];
	assign rd_x   = i0_q + bvfs_pkg::X_W'(corner[0]);
	assign rd_y   = j0_q + bvfs_pkg::Y_W'(corner[1]);

	always_comb begin
		ram_we = (state_q == ST_CLEAR) ||
			(acc_in && req.req_type == bvfs_pkg::REQ_WRITE && wr_ok);
		if (state_q == ST_CLEAR) begin
			ram_addr = clr_addr_q;
			ram_wdata = '{distance: fill_q, dir_x: VW'(bvfs_pkg::ONE_DIR), dir_y: '0,
				radius: '0, tim: '0, vel_x: '0, vel_y: '0};
		end else begin
			ram_addr = (state_q == ST_READ) ? {rd_y, rd_x} :
				{wr_y[bvfs_pkg::Y_W-1:0], wr_x[bvfs_pkg::X_W-1:0]};
			ram_wdata = '{distance: req.in_dist, dir_x: req.in_dir_x, dir_y: req.in_dir_y,
				radius: req.in_radius, tim: req.in_time, vel_x: req.in_vel_x,
				vel_y: req.in_vel_y};
		end
	end

	bvfs_ram #(
		.WIDTH($bits(bvfs_pkg::rec_t)),
		.DEPTH(bvfs_pkg::DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			fill_q     <= '0;
			rd_cnt_q   <= '0;
			v1_s1      <= 1'b0;
		end else begin
			v1_s1 <= (state_q == ST_READ) && (rd_cnt_q >= 3'd1) && (rd_cnt_q <= 3'd4);
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + bvfs_pkg::ADDR_W'(1);
					if (clr_addr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc_in) begin
						case (req.req_type)
							bvfs_pkg::REQ_SAMPLE: begin
								state_q  <= ST_READ;
								rd_cnt_q <= '0;
							end
							bvfs_pkg::REQ_CLEAR: begin
								state_q    <= ST_CLEAR;
								clr_addr_q <= '0;
								fill_q     <= req.in_dist;
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					rd_cnt_q <= rd_cnt_q + 3'd1;
					if (rd_cnt_q == 3'd5) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND:  state_q <= ST_SQUARE;
				ST_SQUARE: state_q <= ST_ROOT;
				ST_ROOT: begin
					if (sqrt_done) begin
						state_q <= (root == '0) ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sample datapath
	assign wgt_sg = $signed({1'b0, wgt_s1});

	always_ff @(posedge clk) begin
		if (acc_in) begin
			i0_q     <= px[bvfs_pkg::PX_W-1:bvfs_pkg::FRAC_BITS];
			j0_q     <= py[bvfs_pkg::PY_W-1:bvfs_pkg::FRAC_BITS];
			wgt_q[0] <= bvfs_pkg::WGT_W'(gx) * bvfs_pkg::WGT_W'(gy);
			wgt_q[1] <= bvfs_pkg::WGT_W'(fx) * bvfs_pkg::WGT_W'(gy);
			wgt_q[2] <= bvfs_pkg::WGT_W'(gx) * bvfs_pkg::WGT_W'(fy);
			wgt_q[3] <= bvfs_pkg::WGT_W'(fx) * bvfs_pkg::WGT_W'(fy);
			acc_vx_q  <= '0;
			acc_vy_q  <= '0;
			acc_rad_q <= '0;
			acc_tim_q <= '0;
			acc_ux_q  <= '0;
			acc_uy_q  <= '0;
		end else if (v1_s1) begin
			acc_vx_q  <= acc_vx_q + AW'(pvx_s1 * wgt_sg);
			acc_vy_q  <= acc_vy_q + AW'(pvy_s1 * wgt_sg);
			acc_rad_q <= acc_rad_q + AW'($signed({1'b0, rad_s1}) * wgt_sg);
			acc_tim_q <= acc_tim_q + AW'($signed({1'b0, tim_s1}) * wgt_sg);
			acc_ux_q  <= acc_ux_q + AW'(ux_s1 * wgt_sg);
			acc_uy_q  <= acc_uy_q + AW'(uy_s1 * wgt_sg);
		end

		// corner products, one corner per cycle behind the read
		pvx_s1 <= $signed({1'b0, ram_rdata.distance}) * $signed(ram_rdata.dir_x);
		pvy_s1 <= $signed({1'b0, ram_rdata.distance}) * $signed(ram_rdata.dir_y);
		rad_s1 <= ram_rdata.radius;
		tim_s1 <= ram_rdata.tim;
		ux_s1  <= $signed(ram_rdata.vel_x);
		uy_s1  <= $signed(ram_rdata.vel_y);
		wgt_s1 <= wgt_q[2'(rd_cnt_q - 3'd1)];

		if (state_q == ST_ROUND) begin
			bx_q  <= bvfs_pkg::BV_W'(rnd(acc_vx_q));
			by_q  <= bvfs_pkg::BV_W'(rnd(acc_vy_q));
			rad_q <= sat_u(rnd(acc_rad_q));
			tim_q <= sat_u(rnd(acc_tim_q));
			ux_q  <= sat_s(rnd(acc_ux_q));
			uy_q  <= sat_s(rnd(acc_uy_q));
		end
		if (state_q == ST_ROOT && sqrt_done) begin
			len_q <= root;
		end
		if (div_done) begin
			qx_q <= q_x;
			qy_q <= q_y;
		end
	end

	assign sqx    = bx_q * bx_q;
	assign sqy    = by_q * by_q;
	assign sq_sum = bvfs_pkg::SQ_W'(sqx) + bvfs_pkg::SQ_W'(sqy);
	assign mag_x  = bx_q[bvfs_pkg::BV_W-1] ? bvfs_pkg::MAG_W'(-bx_q) : bvfs_pkg::MAG_W'(bx_q);
	assign mag_y  = by_q[bvfs_pkg::BV_W-1] ? bvfs_pkg::MAG_W'(-by_q) : bvfs_pkg::MAG_W'(by_q);

	assign sqrt_start = (state_q == ST_SQUARE);
	assign div_start  = (state_q == ST_ROOT) && sqrt_done && (root != '0);

	bvfs_sqrt u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sqrt_start),
		.op    (sq_sum),
		.done  (sqrt_done),
		.root  (root)
	);

	bvfs_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.mag_x (mag_x),
		.mag_y (mag_y),
		.root  (root),
		.done  (div_done),
		.q_x   (q_x),
		.q_y   (q_y)
	);

	// output register
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);
	assign dist_rnd = (len_q >> 14) + bvfs_pkg::ROOT_W'(len_q[13]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_dist_q <= (dist_rnd > bvfs_pkg::ROOT_W'(16'hFFFF)) ? '1 : dist_rnd[VW-1:0];
			if (len_q == '0) begin
				o_dir_x_q <= '0;
				o_dir_y_q <= '0;
			end else begin
				o_dir_x_q <= bx_q[bvfs_pkg::BV_W-1] ? -VW'(qx_q) : VW'(qx_q);
				o_dir_y_q <= by_q[bvfs_pkg::BV_W-1] ? -VW'(qy_q) : VW'(qy_q);
			end
			o_rad_q <= rad_q;
			o_tim_q <= tim_q;
			o_vx_q  <= ux_q;
			o_vy_q  <= uy_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.out_dist   = o_dist_q;
	assign rsp.out_dir_x  = o_dir_x_q;
	assign rsp.out_dir_y  = o_dir_y_q;
	assign rsp.out_radius = o_rad_q;
	assign rsp.out_time   = o_tim_q;
	assign rsp.out_vel_x  = o_vx_q;
	assign rsp.out_vel_y  = o_vy_q;

	// the single RAM port is owned by the corner reads
	a_no_write_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !ram_we)
		else $error("store write during corner reads");

	a_root_in_phase: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> (state_q == ST_ROOT))
		else $error("square root finished outside its phase");

	a_div_in_phase: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divide finished outside its phase");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("result load lost");

endmodule

### verif/bvfs_checker.sv
// Scoreboard for the bilinear vector field sampler: mirrors the record image,
// predicts each sample result and compares it with the result channel.
// Depends on bvfs_pkg and bvfs_intf.
module bvfs_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	bvfs_req_if                        req,
	bvfs_rsp_if                        rsp,
	input  logic                       cfg_wen,
	input  logic [bvfs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bvfs_pkg::DIM_W-1:0] cfg_data,
	output int                         errors,
	output int                         pending,
	output int                         n_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	bvfs_pkg::rec_t image_mem [bvfs_pkg::DEPTH];
	bvfs_pkg::rec_t sample_q [$];
	logic [8:0]     width_reg, height_reg;

	function automatic void fill_image(logic [15:0] fill_val);
		bvfs_pkg::rec_t r;
		r = '0;
		r.distance = fill_val;
		r.dir_x    = 16'(bvfs_pkg::ONE_DIR);
		for (int k = 0; k < bvfs_pkg::DEPTH; k++) image_mem[k] = r;
	endfunction

	function automatic int eff_dim(logic [8:0] v);
		if (v < 2) return 2;
		if (v > 256) return 256;
		return int'(v);
	endfunction

	// weighted sum over 2^16, half away from zero
	function automatic longint round_q16(longint v);
		longint m;
		m = v < 0 ? -v : v;
		m = (m + 32768) >>> 16;
		return v < 0 ? -m : m;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned op);
		longint unsigned res, one;
		res = 0;
		one = 64'd1 << 62;
		while (one > op) one >>= 2;
		while (one != 0) begin
			if (op >= res + one) begin
				op -= res + one;
				res = (res >> 1) + one;
			end else begin
				res >>= 1;
			end
			one >>= 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] unit_comp(longint c, longint unsigned len);
		longint unsigned m, q;
		longint s;
		m = c < 0 ? longint'(-c) : longint'(c);
		q = (m * 32768 + len) / (2 * len);
		if (q > bvfs_pkg::ONE_DIR) q = bvfs_pkg::ONE_DIR;
		s = c < 0 ? -longint'(q) : longint'(q);
		return s[15:0];
	endfunction

	function automatic logic [15:0] sat_u16(longint v);
		if (v < 0) return 16'd0;
		if (v > 65535) return 16'hffff;
		return v[15:0];
	endfunction

	function automatic logic [15:0] sat_s16(longint v);
		if (v < -32768) return 16'h8000;
		if (v > 32767) return 16'h7fff;
		return v[15:0];
	endfunction

	function automatic bvfs_pkg::rec_t predict_sample(logic signed [19:0] cx,
		logic signed [19:0] cy);
		int       w, h, i0, j0, fx, fy;
		longint   hx, hy, px, py, bx, by;
		longint   wt [4];
		longint   acc [7];
		int       addr [4];
		bvfs_pkg::rec_t c, res;
		longint unsigned len, d;
		w  = eff_dim(width_reg);
		h  = eff_dim(height_reg);
		hx = longint'(w - 2) * 256;
		hy = longint'(h - 2) * 256;
		px = cx < 0 ? 0 : (cx > hx ? hx : cx);
		py = cy < 0 ? 0 : (cy > hy ? hy : cy);
		i0 = int'(px >>> 8);
		j0 = int'(py >>> 8);
		fx = int'(px & 255);
		fy = int'(py & 255);
		wt[0] = (256 - fx) * (256 - fy);
		wt[1] = fx * (256 - fy);
		wt[2] = (256 - fx) * fy;
		wt[3] = fx * fy;
		addr[0] = j0 * bvfs_pkg::MAX_WIDTH + i0;
		addr[1] = addr[0] + 1;
		addr[2] = addr[0] + bvfs_pkg::MAX_WIDTH;
		addr[3] = addr[2] + 1;
		for (int k = 0; k < 7; k++) acc[k] = 0;
		for (int k = 0; k < 4; k++) begin
			c = image_mem[addr[k]];
			acc[0] += wt[k] * longint'(c.distance) * longint'($signed(c.dir_x));
			acc[1] += wt[k] * longint'(c.distance) * longint'($signed(c.dir_y));
			acc[2] += wt[k] * longint'(c.radius);
			acc[3] += wt[k] * longint'(c.tim);
			acc[4] += wt[k] * longint'($signed(c.vel_x));
			acc[5] += wt[k] * longint'($signed(c.vel_y));
		end
		bx  = round_q16(acc[0]);
		by  = round_q16(acc[1]);
		len = int_sqrt(longint'(bx * bx) + longint'(by * by));
		res = '0;
		if (len != 0) begin
			d = (len + 8192) >> 14;
			res.distance = d > 65535 ? 16'hffff : d[15:0];
			res.dir_x    = unit_comp(bx, len);
			res.dir_y    = unit_comp(by, len);
		end
		res.radius = sat_u16(round_q16(acc[2]));
		res.tim    = sat_u16(round_q16(acc[3]));
		res.vel_x  = sat_s16(round_q16(acc[4]));
		res.vel_y  = sat_s16(round_q16(acc[5]));
		return res;
	endfunction

	function automatic void store_record(logic signed [19:0] cx, logic signed [19:0] cy,
		bvfs_pkg::rec_t r);
		int xi, yi;
		if (cx < 0 || cy < 0) return;
		xi = int'(cx >>> 8);
		yi = int'(cy >>> 8);
		if (xi >= eff_dim(width_reg) || yi >= eff_dim(height_reg)) return;
		image_mem[yi * bvfs_pkg::MAX_WIDTH + xi] = r;
	endfunction

	string field_name [7] = '{"dist", "dir_x", "dir_y", "radius", "time", "vel_x", "vel_y"};

	always @(posedge clk or negedge arst_n) begin
		bvfs_pkg::rec_t got, exp_rec, wr;
		if (!arst_n) begin
			fill_image(16'd0);
			width_reg  <= 9'd256;
			height_reg <= 9'd256;
			sample_q.delete();
			errors    <= 0;
			n_checked <= 0;
			pending   <= 0;
		end else begin
			if (cfg_wen) begin
				if (cfg_index == bvfs_pkg::REG_IMAGE_WIDTH) width_reg <= cfg_data;
				else if (cfg_index == bvfs_pkg::REG_IMAGE_HEIGHT) height_reg <= cfg_data;
			end
			if (rsp.valid && rsp.ready) begin
				got = {rsp.out_dist, rsp.out_dir_x, rsp.out_dir_y, rsp.out_radius,
					rsp.out_time, rsp.out_vel_x, rsp.out_vel_y};
				n_checked <= n_checked + 1;
				if (sample_q.size() == 0) begin
					$display("%0t: result with no sample request outstanding: %h", $time, got);
					errors <= errors + 1;
				end else begin
					exp_rec = sample_q.pop_front();
					if (got !== exp_rec) begin
						errors <= errors + 1;
						for (int k = 0; k < 7; k++)
							if (got[(6-k)*16 +: 16] !== exp_rec[(6-k)*16 +: 16])
								$display("%0t: %s mismatch: expected %h, actual %h", $time,
									field_name[k], exp_rec[(6-k)*16 +: 16],
									got[(6-k)*16 +: 16]);
					end
				end
			end
			if (req.valid && req.ready) begin
				wr = {req.in_dist, req.in_dir_x, req.in_dir_y, req.in_radius, req.in_time,
					req.in_vel_x, req.in_vel_y};
				case (req.req_type)
					bvfs_pkg::REQ_WRITE:  store_record(req.coord_x, req.coord_y, wr);
					bvfs_pkg::REQ_SAMPLE:
						sample_q.push_back(predict_sample(req.coord_x, req.coord_y));
					bvfs_pkg::REQ_CLEAR:  fill_image(req.in_dist);
					default: ;
				endcase
			end
			pending <= sample_q.size();
		end
	end

endmodule

### verif/tb_top.sv
// Testbench top for the bilinear vector field sampler: clock, reset, request
// and config stimulus, result back-pressure and the verdict.
// Depends on bvfs_pkg, bvfs_intf, the sampler RTL and bvfs_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REQ_NONE  = 2'd3;
	localparam int         RUN_LIMIT = 4000000;
	localparam int         REC_W     = $bits(bvfs_pkg::rec_t);

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [bvfs_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bvfs_pkg::DIM_W-1:0]     cfg_data;
	int   errors, pending, n_checked;
	int   n_writes, n_samples, n_clears;
	int   eff_w, eff_h;
	bit   no_idle;
	bit   sink_hold;
	int   sink_gap;

	bvfs_req_if req ();
	bvfs_rsp_if rsp ();

	bilinear_vector_field_sampler dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	bvfs_checker scoreboard (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .n_checked(n_checked)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bvfs_pkg::rec_t rand_rec();
		bvfs_pkg::rec_t f;
		int   d;
		f = REC_W'({$urandom, $urandom, $urandom, $urandom});
		if ($urandom_range(3) != 0) begin
			d = int'($urandom_range(0, 32768)) - 16384;
			f.dir_x = d[15:0];
			d = int'($urandom_range(0, 32768)) - 16384;
			f.dir_y = d[15:0];
		end
		return f;
	endfunction

	// mostly inside the active image, sometimes anywhere in the 20-bit range
	function automatic logic signed [19:0] rand_coord(int dim);
		logic [31:0] c;
		if ($urandom_range(9) < 8) c = $urandom_range(0, dim * 256 - 1);
		else c = $urandom;
		return c[19:0];
	endfunction

	task automatic send(logic [1:0] kind, logic signed [19:0] cx, logic signed [19:0] cy,
		bvfs_pkg::rec_t f);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk) req.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req.valid     <= 1'b1;
		req.req_type  <= kind;
		req.coord_x   <= cx;
		req.coord_y   <= cy;
		req.in_dist   <= f.distance;
		req.in_dir_x  <= f.dir_x;
		req.in_dir_y  <= f.dir_y;
		req.in_radius <= f.radius;
		req.in_time   <= f.tim;
		req.in_vel_x  <= f.vel_x;
		req.in_vel_y  <= f.vel_y;
		do @(posedge clk); while (!req.ready);
		case (kind)
			bvfs_pkg::REQ_WRITE:  n_writes++;
			bvfs_pkg::REQ_SAMPLE: n_samples++;
			bvfs_pkg::REQ_CLEAR:  n_clears++;
			default: ;
		endcase
	endtask

	// final sample also proves any clear ahead of it has finished
	task automatic drain();
		send(bvfs_pkg::REQ_SAMPLE, rand_coord(eff_w), rand_coord(eff_h), rand_rec());
		@(negedge clk) req.valid <= 1'b0;
		wait (pending == 0);
		repeat (100) @(negedge clk);
	endtask

	task automatic set_dims(logic [8:0] w, logic [8:0] h);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= bvfs_pkg::REG_IMAGE_WIDTH;
		cfg_data  <= w;
		@(negedge clk);
		cfg_index <= bvfs_pkg::REG_IMAGE_HEIGHT;
		cfg_data  <= h;
		@(negedge clk) cfg_wen <= 1'b0;
		eff_w = w < 2 ? 2 : (w > 256 ? 256 : int'(w));
		eff_h = h < 2 ? 2 : (h > 256 ? 256 : int'(h));
	endtask

	task automatic run_random(int count);
		int   r;
		bvfs_pkg::rec_t f;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			f = rand_rec();
			if (r < 47) send(bvfs_pkg::REQ_SAMPLE, rand_coord(eff_w), rand_coord(eff_h), f);
			else if (r < 95) send(bvfs_pkg::REQ_WRITE, rand_coord(eff_w), rand_coord(eff_h), f);
			else begin
				send(REQ_NONE, rand_coord(eff_w), rand_coord(eff_h), f);
				n--;
			end
		end
	endtask

	// result side: random gaps, plus one long hold-off on request
	initial begin
		rsp.ready = 1'b0;
		sink_gap  = 0;
		forever begin
			@(negedge clk);
			if (sink_hold) begin
				rsp.ready <= 1'b0;
				repeat (600) @(negedge clk);
				sink_hold = 0;
			end
			if (sink_gap > 0) begin
				rsp.ready <= 1'b0;
				sink_gap--;
			end else begin
				rsp.ready <= 1'b1;
				sink_gap = pick_gap();
			end
		end
	end

	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles", RUN_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		bvfs_pkg::rec_t f;
		logic [8:0] dims [6][2] = '{'{9'd2, 9'd2}, '{9'd0, 9'd1}, '{9'd511, 9'd300},
			'{9'd4, 9'd3}, '{9'd256, 9'd2}, '{9'd3, 9'd256}};
		arst_n    = 1'b0;
		cfg_wen   = 1'b0;
		cfg_index = bvfs_pkg::REG_IMAGE_WIDTH;
		cfg_data  = '0;
		req.valid = 1'b0;
		req.req_type = bvfs_pkg::REQ_WRITE;
		{req.coord_x, req.coord_y, req.in_dist, req.in_dir_x, req.in_dir_y} = '0;
		{req.in_radius, req.in_time, req.in_vel_x, req.in_vel_y} = '0;
		no_idle   = 0;
		sink_hold = 0;
		n_writes  = 0;
		n_samples = 0;
		n_clears  = 0;
		eff_w = 256;
		eff_h = 256;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed: reset image gives a zero vector
		send(bvfs_pkg::REQ_SAMPLE, 20'sd0, 20'sd0, rand_rec());
		f = '{16'hffff, 16'sd16384, 16'sd0, 16'hffff, 16'hffff, 16'h7fff, 16'h8000};
		send(bvfs_pkg::REQ_WRITE, 20'sd0, 20'sd0, f);
		f = '{16'hffff, -16'sd16384, 16'sd16384, 16'hffff, 16'd0, 16'h8000, 16'h7fff};
		send(bvfs_pkg::REQ_WRITE, 20'sd65535, 20'sd65535, f);
		f = '{16'hffff, 16'h8000, 16'h7fff, 16'h1234, 16'h8765, 16'h8000, 16'h8000};
		send(bvfs_pkg::REQ_WRITE, 20'sd256, 20'sd0, f);
		send(bvfs_pkg::REQ_WRITE, -20'sd1, 20'sd0, rand_rec());
		send(bvfs_pkg::REQ_WRITE, 20'sd65536, 20'sd512, rand_rec());
		send(bvfs_pkg::REQ_WRITE, 20'sd512, 20'sh7ffff, rand_rec());
		send(bvfs_pkg::REQ_SAMPLE, 20'sd0, 20'sd0, rand_rec());
		send(bvfs_pkg::REQ_SAMPLE, 20'sd128, 20'sd77, rand_rec());
		send(bvfs_pkg::REQ_SAMPLE, -20'sd524288, -20'sd524288, rand_rec());
		send(bvfs_pkg::REQ_SAMPLE, 20'sd524287, 20'sd524287, rand_rec());
		send(bvfs_pkg::REQ_SAMPLE, 20'sd65151, 20'sd65100, rand_rec());
		send(REQ_NONE, 20'sd0, 20'sd0, rand_rec());
		send(bvfs_pkg::REQ_CLEAR, 20'sd0, 20'sd0,
			'{16'hffff, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
		send(bvfs_pkg::REQ_SAMPLE, 20'sd300, 20'sd1000, rand_rec());
		send(bvfs_pkg::REQ_CLEAR, 20'sd0, 20'sd0, rand_rec());
		send(bvfs_pkg::REQ_SAMPLE, 20'sd33333, 20'sd4444, rand_rec());
		drain();

		for (int p = 0; p < 6; p++) begin
			set_dims(dims[p][0], dims[p][1]);
			no_idle = (p == 1);
			if (p == 3) begin
				send(bvfs_pkg::REQ_CLEAR, 20'sd0, 20'sd0, rand_rec());
				run_random(40);
				sink_hold = 1;
				for (int n = 0; n < 12; n++)
					send(bvfs_pkg::REQ_SAMPLE, rand_coord(eff_w), rand_coord(eff_h),
						rand_rec());
				@(negedge clk) req.valid <= 1'b0;
				wait (pending == 0);
				run_random(50);
			end else begin
				run_random(100);
			end
			drain();
		end

		$display("covered %0d writes, %0d samples, %0d clears over 7 image sizes",
			n_writes, n_samples, n_clears);
		$display("%0d results compared", n_checked);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### filelist.f
design/bvfs_pkg.sv
design/bvfs_intf.sv
design/bvfs_ram.sv
design/bvfs_sqrt.sv
design/bvfs_div.sv
design/bilinear_vector_field_sampler.sv
verif/bvfs_checker.sv
verif/tb_top.sv
